>>> src/huffman_bit_packer_assert.svh
// Assertion helpers for the packer datapath module.
// Both sample on clock and are disabled while reset is high.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// Check that a condition holds at every edge.
`define HBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that the consequent holds whenever the antecedent does.
`define HBP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> src/hbp_pkg.sv
package hbp_pkg;

   localparam int MAX_CODE_LEN_DEF  = 32;
   localparam int ALPHABET_SIZE_DEF = 256;

   localparam int OP_W    = 2;
   localparam int SYM_W   = 8;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 4;
   localparam int ENTRY_W = WORD_W + LEN_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_PACK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic write;    // store a code entry
      logic capture;  // read the symbol's entry
      logic align;    // left-align the code bits
      logic step;     // pack one chunk, emit a full byte
      logic flush;    // emit the pending byte and clear
   } dp_cmd_type;

   typedef struct packed {
      logic sym_ok;
      logic rem_zero;
      logic full;
      logic out_free;
   } dp_status_type;

endpackage

>>> src/hbp_ctrl.sv
module hbp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [hbp_pkg::OP_W-1:0]  req_opcode,
   input  hbp_pkg::dp_status_type    status,
   output hbp_pkg::dp_cmd_type       cmd
);
   import hbp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_ENCODE: begin
                     if (status.sym_ok) state_in = ST_READ;
                  end
                  OP_FLUSH: state_in = ST_FLUSH;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_PACK;
         ST_PACK: begin
            if (status.rem_zero) state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      cmd         = '0;
      cmd.write   = accept && (req_opcode == OP_LOAD) && status.sym_ok;
      cmd.capture = accept && (req_opcode == OP_ENCODE) && status.sym_ok;
      unique case (state_ff)
         ST_READ:  cmd.align = 1'b1;
         // hold while a full byte has nowhere to go
         ST_PACK:  cmd.step  = !status.rem_zero && (!status.full || status.out_free);
         ST_FLUSH: cmd.flush = status.out_free;
         default:  cmd.align = 1'b0;
      endcase
   end

endmodule

>>> src/hbp_datapath.sv
`include "huffman_bit_packer_assert.svh"

module hbp_datapath #(
   parameter int MAX_CODE_LEN  = hbp_pkg::MAX_CODE_LEN_DEF,
   parameter int ALPHABET_SIZE = hbp_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hbp_pkg::dp_cmd_type         cmd,
   output hbp_pkg::dp_status_type      status,
   input  logic [hbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hbp_pkg::WORD_W-1:0]  req_code_word,
   input  logic [hbp_pkg::LEN_W-1:0]   req_code_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hbp_pkg::BYTE_W-1:0]  rsp_packed_byte,
   output logic                        rsp_last_of_run
);
   import hbp_pkg::*;

   localparam int AW  = $clog2(ALPHABET_SIZE);
   localparam int CAP = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
   localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(ALPHABET_SIZE);
   localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(CAP);

   logic [ENTRY_W-1:0] code_mem [ALPHABET_SIZE];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [WORD_W-1:0] word_ff, word_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [AW-1:0]     idx;
   logic [LEN_W-1:0]  len_sat;
   logic [LEN_W-1:0]  rd_len;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] aligned;
   logic              full;
   logic              emit_byte;
   logic [BYTE_W-1:0] base_byte;
   logic [CNT_W-1:0]  base_cnt;
   logic [CNT_W-1:0]  room;
   logic [CNT_W-1:0]  take;

   assign idx     = req_symbol[AW-1:0];
   assign len_sat = (req_code_length > LEN_CAP) ? LEN_CAP : req_code_length;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         code_mem[idx] <= {req_code_word, len_sat};
      end
      if (cmd.capture) begin
         rd_data_ff <= code_mem[idx];
      end
   end

   assign rd_len  = rd_data_ff[LEN_W-1:0];
   assign rd_word = rd_data_ff[ENTRY_W-1:LEN_W];
   // first-sent bit to the top, zeros below the code
   assign aligned = rd_word << (LEN_W'(WORD_W) - rd_len);

   assign full      = (pend_cnt_ff == CNT_W'(BYTE_W));
   assign emit_byte = cmd.step && full;
   assign base_byte = full ? '0 : pend_byte_ff;
   assign base_cnt  = full ? '0 : pend_cnt_ff;
   assign room      = CNT_W'(BYTE_W) - base_cnt;
   assign take      = (rem_ff < LEN_W'(room)) ? rem_ff[CNT_W-1:0] : room;

   always_comb begin
      word_in      = word_ff;
      rem_in       = rem_ff;
      pend_byte_in = pend_byte_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (cmd.align) begin
         word_in = aligned;
         rem_in  = rd_len;
      end
      if (cmd.step) begin
         word_in      = word_ff << take;
         rem_in       = rem_ff - LEN_W'(take);
         pend_byte_in = base_byte | (word_ff[WORD_W-1 -: BYTE_W] >> base_cnt);
         pend_cnt_in  = base_cnt + take;
      end
      if (cmd.flush) begin
         pend_byte_in = '0;
         pend_cnt_in  = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_byte) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = pend_byte_ff;
         // no further byte once the rest fits into the fresh one
         rsp_last_in  = (rem_ff <= LEN_W'(BYTE_W));
      end else if (cmd.flush) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = pend_byte_ff;
         rsp_last_in  = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         pend_byte_ff <= '0;
         pend_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         pend_byte_ff <= pend_byte_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.sym_ok   = ({1'b0, req_symbol} < SYM_LIMIT);
   assign status.rem_zero = (rem_ff == '0);
   assign status.full     = full;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `HBP_ASSERT(a_pend_cnt_bound, pend_cnt_ff <= CNT_W'(BYTE_W), "pending count above a byte")
   `HBP_ASSERT_IMPL(a_empty_is_zero, pend_cnt_ff == '0, pend_byte_ff == '0, "stale pending bits")
   `HBP_ASSERT_IMPL(a_step_has_bits, cmd.step, rem_ff != '0, "pack step with no bits left")
   `HBP_ASSERT_IMPL(a_no_overwrite, emit_byte || cmd.flush, status.out_free, "held byte overwritten")

endmodule

>>> src/huffman_bit_packer.sv
// Huffman bit packer: a load beat writes one symbol's code word and length into a
// table, an encode beat packs that symbol's code MSB first into bytes, and a flush
// beat emits the pending byte zero padded (a zero byte when nothing is pending) and
// clears the packer. One beat is handled at a time. A load is written from the idle
// state; a flush waits until the result side can take its byte; an encode reads the
// symbol's entry from the registered single-port code table, aligns the code, then
// packs it in up to 5 steps for a 32-bit code, moving at most one byte's worth of
// bits per cycle while no full byte is held up by a stall on the result side.
module huffman_bit_packer #(
   parameter int MAX_CODE_LEN  = hbp_pkg::MAX_CODE_LEN_DEF,
   parameter int ALPHABET_SIZE = hbp_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hbp_pkg::OP_W-1:0]    req_opcode,
   input  logic [hbp_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hbp_pkg::WORD_W-1:0]  req_code_word,
   input  logic [hbp_pkg::LEN_W-1:0]   req_code_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hbp_pkg::BYTE_W-1:0]  rsp_packed_byte,
   output logic                        rsp_last_of_run
);
   import hbp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   hbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   hbp_datapath #(
      .MAX_CODE_LEN  (MAX_CODE_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
